// ===== sv/bfca_pkg.sv =====
// ----------------------------------------------------------------------------
// bfca_pkg
// Shared constants, codes and types of the best-fit coalescing allocator.
// ----------------------------------------------------------------------------
package bfca_pkg;

  localparam int FREE_ENTRIES = 32;
  localparam int ADDR_BITS    = 48;
  localparam int IDX_BITS     = $clog2(FREE_ENTRIES);
  localparam int GRAN_BITS    = 5;
  localparam int CFG_IDX_BITS = 2;
  localparam int ENTRY_BITS   = 2 * ADDR_BITS;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [IDX_BITS-1:0]  idx_t;

  // Request opcodes
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_RESERVE = 2'd1,
    STAT_FULL    = 2'd2
  } status_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_BASE    = 2'd0,
    CFG_RESERVE = 2'd1,
    CFG_GRANULE = 2'd2
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SUM,
    S_CONS,
    S_NEED,
    S_QUOT,
    S_GROW,
    S_TAIL,
    S_COMMIT
  } state_t;

  // Findings of one pass over the free table
  typedef struct packed {
    logic  best_found;
    idx_t  best_idx;
    addr_t best_start;
    addr_t best_len;
    logic  top_found;
    idx_t  top_idx;
    addr_t top_start;
    addr_t top_len;
    logic  dup;
    logic  succ_found;
    idx_t  succ_idx;
    addr_t succ_len;
    logic  pred_found;
    idx_t  pred_idx;
    addr_t pred_start;
    addr_t pred_len;
  } scan_res_t;

endpackage

// ===== sv/bfca_ram.sv =====
// ----------------------------------------------------------------------------
// bfca_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/bfca_scan.sv =====
// ----------------------------------------------------------------------------
// bfca_scan
// Walks the free table one entry a cycle and tracks the best fit, the top
// block, a duplicate start, the successor and the predecessor of a request.
// ----------------------------------------------------------------------------
module bfca_scan import bfca_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  addr_t                   size,
  input  addr_t                   addr,
  input  addr_t                   succ_addr,
  input  logic [FREE_ENTRIES-1:0] valid,
  input  logic [ENTRY_BITS-1:0]   rdata,
  output idx_t                    raddr,
  output logic                    done,
  output scan_res_t               res
);

  localparam idx_t LAST = idx_t'(FREE_ENTRIES - 1);

  logic  busy;
  idx_t  cnt;
  logic  rv;
  idx_t  ridx;
  addr_t e_start;
  addr_t e_len;
  logic  e_v;
  logic  take_best;
  logic  take_top;
  logic  take_succ;
  logic  take_pred;

  assign raddr   = cnt;
  assign e_start = rdata[ENTRY_BITS-1:ADDR_BITS];
  assign e_len   = rdata[ADDR_BITS-1:0];
  assign e_v     = valid[ridx];

  // Compare the returned entry against the running picks
  always_comb begin
    take_best = e_v && (e_len >= size) &&
                (!res.best_found || (e_len < res.best_len) ||
                 ((e_len == res.best_len) && (e_start < res.best_start)));
    take_top  = e_v && (!res.top_found || (e_start > res.top_start));
    take_succ = e_v && !res.succ_found && (e_start == succ_addr);
    take_pred = e_v && !take_succ && (e_start < addr) &&
                (!res.pred_found || (e_start > res.pred_start));
  end

  // Advance the read address
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      rv   <= 1'b0;
      done <= 1'b0;
    end else begin
      rv   <= busy;
      done <= rv && (ridx == LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + idx_t'(1);
        if (cnt == LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    ridx <= cnt;
  end

  // Accumulate the picks
  always_ff @(posedge clk) begin
    if (rst || start) begin
      res.best_found <= 1'b0;
      res.top_found  <= 1'b0;
      res.dup        <= 1'b0;
      res.succ_found <= 1'b0;
      res.pred_found <= 1'b0;
    end else if (rv) begin
      if (take_best) begin
        res.best_found <= 1'b1;
        res.best_idx   <= ridx;
        res.best_start <= e_start;
        res.best_len   <= e_len;
      end
      if (take_top) begin
        res.top_found <= 1'b1;
        res.top_idx   <= ridx;
        res.top_start <= e_start;
        res.top_len   <= e_len;
      end
      if (e_v && (e_start == addr)) begin
        res.dup <= 1'b1;
      end
      if (take_succ) begin
        res.succ_found <= 1'b1;
        res.succ_idx   <= ridx;
        res.succ_len   <= e_len;
      end
      if (take_pred) begin
        res.pred_found <= 1'b1;
        res.pred_idx   <= ridx;
        res.pred_start <= e_start;
        res.pred_len   <= e_len;
      end
    end
  end

endmodule

// ===== sv/best_fit_coalescing_allocator.sv =====
// ----------------------------------------------------------------------------
// best_fit_coalescing_allocator
// Takes one request at a time; the pass over the 32-entry free table goes
// through one RAM read port and ends before the next request is taken.
// A finished result waits in an output register; the next request is taken.
// Reset empties the table (valid bits cleared), zeroes the heap size and sets
// base 0, reserve 0, granule log2 12. No clearing pass is needed.
// ----------------------------------------------------------------------------
module best_fit_coalescing_allocator import bfca_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [ADDR_BITS-1:0]    cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    opcode,
  input  logic [ADDR_BITS-1:0]    req_size,
  input  logic [ADDR_BITS-1:0]    req_addr,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ADDR_BITS-1:0]    result_addr,
  output logic [1:0]              status
);

  state_t state;
  state_t state_next;

  addr_t                 base_addr;
  addr_t                 reserve_size;
  logic [GRAN_BITS-1:0]  granule_log2;
  addr_t                 heap_used;
  addr_t                 heap_next;
  logic [FREE_ENTRIES-1:0] valid;
  logic [FREE_ENTRIES-1:0] valid_next;

  logic      in_fire;
  logic      commit;
  logic      scan_done;
  idx_t      raddr;
  logic [ENTRY_BITS-1:0] rdata;
  scan_res_t sr;

  // Request registers and intermediate results
  opcode_t op_r;
  addr_t   size_r;
  addr_t   addr_r;
  addr_t   next_r;
  addr_t   end_r;
  addr_t   avail_r;
  addr_t   top_end;
  addr_t   pred_end;
  addr_t   best_rem;
  addr_t   best_nstart;
  logic    best_gt;
  logic    cons_r;
  logic    merge_r;
  addr_t   total_r;
  addr_t   need_r;
  addr_t   ret_r;
  addr_t   pred_newlen;
  addr_t   q_r;
  addr_t   availq_r;
  logic    need_zero;
  addr_t   grow_r;
  logic    fail_r;
  logic    tail_r;
  addr_t   tail_start;
  addr_t   tail_len;
  addr_t   gmask;

  // Commit-stage signals
  logic [FREE_ENTRIES-1:0] vmask;
  logic    any_empty;
  idx_t    slot;
  logic    mem_we;
  idx_t    mem_waddr;
  logic [ENTRY_BITS-1:0] mem_wdata;
  addr_t   result_addr_next;
  status_t res_status;

  assign gmask = (addr_t'(1) << granule_log2) - addr_t'(1);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      base_addr    <= '0;
      reserve_size <= '0;
      granule_log2 <= GRAN_BITS'(12);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BASE:    base_addr    <= cfg_data;
        CFG_RESERVE: reserve_size <= cfg_data;
        CFG_GRANULE: granule_log2 <= cfg_data[GRAN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_SCAN;
      S_SCAN:   if (scan_done) state_next = S_SUM;
      S_SUM:    state_next = S_CONS;
      S_CONS:   state_next = S_NEED;
      S_NEED:   state_next = S_QUOT;
      S_QUOT:   state_next = S_GROW;
      S_GROW:   state_next = S_TAIL;
      S_TAIL:   state_next = S_COMMIT;
      S_COMMIT: if (!out_valid || out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_ready = 1'b0;
    commit   = 1'b0;
    case (state)
      S_IDLE:   in_ready = 1'b1;
      S_COMMIT: commit   = !out_valid || out_ready;
      default: ;
    endcase
  end

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the request and the heap end
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= opcode_t'(opcode);
      size_r  <= req_size;
      addr_r  <= req_addr;
      next_r  <= req_addr + req_size;
      end_r   <= base_addr + heap_used;
      avail_r <= (reserve_size > heap_used) ? (reserve_size - heap_used) : '0;
    end
  end

  // Evaluate the scan findings, one step per state
  always_ff @(posedge clk) begin
    case (state)
      S_SUM: begin
        top_end     <= sr.top_start + sr.top_len;
        pred_end    <= sr.pred_start + sr.pred_len;
        best_rem    <= sr.best_len - size_r;
        best_nstart <= sr.best_start + size_r;
        best_gt     <= sr.best_len > size_r;
      end
      S_CONS: begin
        cons_r  <= sr.top_found && (top_end == end_r);
        merge_r <= sr.pred_found && (pred_end == addr_r);
        total_r <= size_r + (sr.succ_found ? sr.succ_len : '0);
      end
      S_NEED: begin
        need_r      <= size_r - (cons_r ? sr.top_len : '0);
        ret_r       <= cons_r ? sr.top_start : end_r;
        pred_newlen <= sr.pred_len + total_r;
      end
      S_QUOT: begin
        q_r       <= (need_r >> granule_log2) + addr_t'(|(need_r & gmask));
        availq_r  <= avail_r >> granule_log2;
        need_zero <= need_r == '0;
      end
      S_GROW: begin
        grow_r <= q_r << granule_log2;
        fail_r <= need_zero || (q_r > availq_r);
      end
      S_TAIL: begin
        tail_r     <= grow_r > need_r;
        tail_start <= end_r + need_r;
        tail_len   <= grow_r - need_r;
      end
      default: ;
    endcase
  end

  // Lowest free entry once the absorbed or merged block is dropped
  always_comb begin
    vmask = valid;
    if (op_r == OP_ALLOC) begin
      if (cons_r) vmask[sr.top_idx] = 1'b0;
    end else begin
      if (sr.succ_found) vmask[sr.succ_idx] = 1'b0;
    end
    any_empty = 1'b0;
    slot      = '0;
    for (int i = FREE_ENTRIES - 1; i >= 0; i--) begin
      if (!vmask[i]) begin
        any_empty = 1'b1;
        slot      = idx_t'(i);
      end
    end
  end

  // Decide the outcome and the table update
  always_comb begin
    valid_next       = valid;
    heap_next        = heap_used;
    mem_we           = 1'b0;
    mem_waddr        = slot;
    mem_wdata        = {tail_start, tail_len};
    result_addr_next = '0;
    res_status       = STAT_OK;
    if (op_r == OP_ALLOC) begin
      if (sr.best_found) begin
        result_addr_next = sr.best_start;
        if (best_gt) begin
          mem_we    = 1'b1;
          mem_waddr = sr.best_idx;
          mem_wdata = {best_nstart, best_rem};
        end else begin
          valid_next[sr.best_idx] = 1'b0;
        end
      end else if (fail_r) begin
        res_status = STAT_RESERVE;
      end else if (tail_r && !cons_r && !any_empty) begin
        res_status = STAT_FULL;
      end else begin
        result_addr_next = ret_r;
        heap_next        = heap_used + grow_r;
        if (cons_r) valid_next[sr.top_idx] = 1'b0;
        if (tail_r) begin
          mem_we           = 1'b1;
          valid_next[slot] = 1'b1;
        end
      end
    end else begin
      if (size_r == '0 || sr.dup) begin
        res_status = STAT_OK;
      end else if (!merge_r && !sr.succ_found && !any_empty) begin
        res_status = STAT_FULL;
      end else begin
        if (sr.succ_found) valid_next[sr.succ_idx] = 1'b0;
        mem_we = 1'b1;
        if (merge_r) begin
          mem_waddr = sr.pred_idx;
          mem_wdata = {sr.pred_start, pred_newlen};
        end else begin
          mem_wdata        = {addr_r, total_r};
          valid_next[slot] = 1'b1;
        end
      end
    end
  end

  // Apply the update and hold the result until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      heap_used <= '0;
      out_valid <= 1'b0;
    end else begin
      if (commit) begin
        valid     <= valid_next;
        heap_used <= heap_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      result_addr <= result_addr_next;
      status      <= res_status;
    end
  end

  bfca_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (FREE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (commit && mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  bfca_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (in_fire),
    .size      (size_r),
    .addr      (addr_r),
    .succ_addr (next_r),
    .valid     (valid),
    .rdata     (rdata),
    .raddr     (raddr),
    .done      (scan_done),
    .res       (sr)
  );

endmodule

// ===== sv/bfca_checker.sv =====
// ----------------------------------------------------------------------------
// bfca_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bfca_checker import bfca_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [ADDR_BITS-1:0] result_addr,
  input logic [1:0]           status
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_addr) && $stable(status))
    else $error("result changed while stalled");

  // Take one request at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // Failures return a zero address; frees do too, but only failures are asserted
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_RESERVE || status == STAT_FULL) |-> result_addr == '0)
    else $error("nonzero address on failure");

  // Drop results on reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind best_fit_coalescing_allocator bfca_checker u_bfca_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .result_addr (result_addr),
  .status      (status)
);

// ===== dv/best_fit_coalescing_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// best_fit_coalescing_allocator_tb
// Self-checking bench for the best-fit allocator. A directed table covers the
// corner cases (empty table, zero sizes, double free, wrap at the top of the
// address space, merges). Random phases under several register settings then
// follow. They mix alloc/free traffic on live blocks, fragmenting bursts that
// fill the free table, and noise requests. Each result is checked against a
// built-in model of the free table and the heap end.
// ----------------------------------------------------------------------------
module best_fit_coalescing_allocator_tb;
  import bfca_pkg::*;

  localparam int   PHASES      = 6;
  localparam int   PHASE_ITEMS = 330;
  localparam int   DRAIN_WAIT  = 60;
  localparam int   HOLD_CYCLES = 400;
  localparam int   GROW_ROW    = 12;
  localparam addr_t AMAX       = {ADDR_BITS{1'b1}};

  typedef struct {
    opcode_t op;
    addr_t   size;
    addr_t   addr;
    bit      typed;
    addr_t   t_addr;
    status_t t_stat;
  } req_row_t;

  typedef struct {
    addr_t   addr;
    status_t stat;
  } alloc_result_t;

  typedef struct {
    addr_t addr;
    addr_t size;
  } live_block_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = CFG_BASE;
  logic [ADDR_BITS-1:0]    cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    opcode = OP_ALLOC;
  logic [ADDR_BITS-1:0]    req_size = '0;
  logic [ADDR_BITS-1:0]    req_addr = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [ADDR_BITS-1:0]    result_addr;
  logic [1:0]              status;

  best_fit_coalescing_allocator i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .req_size(req_size), .req_addr(req_addr),
    .out_valid(out_valid), .out_ready(out_ready), .result_addr(result_addr),
    .status(status)
  );

  always #1 clk = ~clk;

  // Shadow allocator state
  addr_t          tbl_start [FREE_ENTRIES];
  addr_t          tbl_len   [FREE_ENTRIES];
  bit             tbl_used  [FREE_ENTRIES];
  addr_t          heap_size;
  addr_t          reg_base;
  addr_t          reg_reserve;
  logic [4:0]     reg_gran;

  alloc_result_t  pending_results[$];
  live_block_t    live_blocks[$];
  int             errors = 0;
  int             mismatches = 0;
  int             results_seen = 0;
  int             items_sent = 0;
  int             n_alloc_ok = 0;
  int             n_reserve = 0;
  int             n_full = 0;
  bit             no_idle = 1'b0;
  bit             hold_req = 1'b0;
  int             hold_cnt = 0;

  function automatic int first_free_slot();
    for (int i = 0; i < FREE_ENTRIES; i++)
      if (!tbl_used[i]) return i;
    return -1;
  endfunction

  function automatic status_t table_alloc(input addr_t size, output addr_t ra);
    int          best;
    int          top;
    int          slot;
    addr_t       hend;
    addr_t       need;
    addr_t       avail;
    logic [63:0] q;
    logic [63:0] grow;
    logic [63:0] gmask;
    bit          cons;
    bit          tail;
    best = -1;
    top = -1;
    ra = '0;
    // Smallest fitting block, lowest start on ties
    for (int i = 0; i < FREE_ENTRIES; i++) begin
      if (!tbl_used[i] || tbl_len[i] < size) continue;
      if (best < 0 || tbl_len[i] < tbl_len[best] ||
          (tbl_len[i] == tbl_len[best] && tbl_start[i] < tbl_start[best]))
        best = i;
    end
    if (best >= 0) begin
      ra = tbl_start[best];
      if (tbl_len[best] > size) begin
        tbl_start[best] = tbl_start[best] + size;
        tbl_len[best]   = tbl_len[best] - size;
      end else begin
        tbl_used[best] = 1'b0;
      end
      return STAT_OK;
    end
    // Grow the heap, absorbing a free block that touches its end
    hend = reg_base + heap_size;
    for (int i = 0; i < FREE_ENTRIES; i++)
      if (tbl_used[i] && (top < 0 || tbl_start[i] > tbl_start[top])) top = i;
    cons = top >= 0 && addr_t'(tbl_start[top] + tbl_len[top]) == hend;
    need = size;
    ra = hend;
    if (cons) begin
      ra = tbl_start[top];
      need = need - tbl_len[top];
    end
    if (need == 0) begin
      ra = '0;
      return STAT_RESERVE;
    end
    avail = (reg_reserve > heap_size) ? reg_reserve - heap_size : '0;
    gmask = (64'd1 << reg_gran) - 1;
    q = 64'(need) >> reg_gran;
    if ((64'(need) & gmask) != 0) q++;
    if (q > (64'(avail) >> reg_gran)) begin
      ra = '0;
      return STAT_RESERVE;
    end
    grow = q << reg_gran;
    tail = grow > 64'(need);
    if (tail && !cons && first_free_slot() < 0) begin
      ra = '0;
      return STAT_FULL;
    end
    heap_size = heap_size + addr_t'(grow);
    if (cons) tbl_used[top] = 1'b0;
    if (tail) begin
      slot = first_free_slot();
      if (slot >= 0) begin
        tbl_start[slot] = hend + need;
        tbl_len[slot]   = addr_t'(grow - 64'(need));
        tbl_used[slot]  = 1'b1;
      end
    end
    return STAT_OK;
  endfunction

  function automatic status_t table_free(input addr_t addr, input addr_t size);
    int    succ;
    int    pred;
    int    slot;
    addr_t nxt;
    addr_t total;
    bit    merge_pred;
    succ = -1;
    pred = -1;
    if (size == 0) return STAT_OK;
    // Drop a double free
    for (int i = 0; i < FREE_ENTRIES; i++)
      if (tbl_used[i] && tbl_start[i] == addr) return STAT_OK;
    nxt = addr + size;
    for (int i = 0; i < FREE_ENTRIES; i++)
      if (tbl_used[i] && tbl_start[i] == nxt) begin
        succ = i;
        break;
      end
    for (int i = 0; i < FREE_ENTRIES; i++) begin
      if (!tbl_used[i] || i == succ || tbl_start[i] >= addr) continue;
      if (pred < 0 || tbl_start[i] > tbl_start[pred]) pred = i;
    end
    merge_pred = pred >= 0 && addr_t'(tbl_start[pred] + tbl_len[pred]) == addr;
    if (!merge_pred && succ < 0 && first_free_slot() < 0) return STAT_FULL;
    total = size;
    if (succ >= 0) begin
      total = total + tbl_len[succ];
      tbl_used[succ] = 1'b0;
    end
    if (merge_pred) begin
      tbl_len[pred] = tbl_len[pred] + total;
    end else begin
      slot = first_free_slot();
      if (slot >= 0) begin
        tbl_start[slot] = addr;
        tbl_len[slot]   = total;
        tbl_used[slot]  = 1'b1;
      end
    end
    return STAT_OK;
  endfunction

  // Predict, record, and offer one request; returns the predicted result
  task automatic issue(input req_row_t row, output alloc_result_t res);
    alloc_result_t exp_res;
    if (row.op == OP_ALLOC) begin
      exp_res.stat = table_alloc(row.size, exp_res.addr);
      if (exp_res.stat == STAT_OK) begin
        n_alloc_ok++;
        if (row.size != 0 && live_blocks.size() < 300)
          live_blocks.push_back('{exp_res.addr, row.size});
      end
    end else begin
      exp_res.addr = '0;
      exp_res.stat = table_free(row.addr, row.size);
    end
    if (exp_res.stat == STAT_RESERVE) n_reserve++;
    if (exp_res.stat == STAT_FULL) n_full++;
    res = exp_res;
    if (row.typed) begin
      exp_res.addr = row.t_addr;
      exp_res.stat = row.t_stat;
    end
    pending_results.push_back(exp_res);
    // Idle the input at random
    while (!no_idle && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= row.op;
    req_size <= row.size;
    req_addr <= row.addr;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send(input opcode_t op, input addr_t size, input addr_t addr);
    alloc_result_t r;
    issue('{op, size, addr, 1'b0, '0, STAT_OK}, r);
  endtask

  // Wait until the block is idle, then write all three registers
  task automatic configure(input addr_t base, input addr_t rsv, input logic [4:0] g);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_results.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_BASE; cfg_data <= base;
    @(posedge clk);
    cfg_index <= CFG_RESERVE; cfg_data <= rsv;
    @(posedge clk);
    cfg_index <= CFG_GRANULE; cfg_data <= addr_t'(g);
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_base = base;
    reg_reserve = rsv;
    reg_gran = g;
  endtask

  function automatic addr_t rand_addr();
    return {16'($urandom_range(16'hffff)), $urandom()};
  endfunction

  function automatic addr_t rand_small_size();
    case ($urandom_range(9))
      0:       return '0;
      1, 2, 3: return addr_t'($urandom_range(1, 64));
      4, 5, 6: return addr_t'($urandom_range(1, 8192));
      7:       return addr_t'(1) << $urandom_range(0, 20);
      default: return addr_t'($urandom_range(1, 1 << 20));
    endcase
  endfunction

  // Drive the output side: random stalls, or a long counted hold-off
  always @(posedge clk) begin
    if (hold_req && hold_cnt == 0) begin
      hold_cnt <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= 16);
    end
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    alloc_result_t exp_res;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        if (mismatches++ < 10)
          $display("unexpected result addr=%h status=%0d", result_addr, status);
      end else begin
        exp_res = pending_results.pop_front();
        if (result_addr !== exp_res.addr || status !== exp_res.stat) begin
          errors++;
          if (mismatches++ < 10)
            $display("result %0d: expected addr=%h status=%0d, got addr=%h status=%0d",
                     results_seen, exp_res.addr, exp_res.stat, result_addr, status);
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("timeout: %0d results still expected", pending_results.size());
    $display("best_fit_coalescing_allocator_tb NOT OK");
    $finish;
  end

  initial begin
    req_row_t      dir_rows[$];
    req_row_t      row;
    alloc_result_t r;
    live_block_t   blk;
    live_block_t   burst[$];
    addr_t         sz;
    int            k;
    int            n;
    int            cnt;
    bit            hold_started;
    addr_t         ph_base [PHASES];
    addr_t         ph_rsv  [PHASES];
    logic [4:0]    ph_gran [PHASES];

    hold_started = 1'b0;
    for (int i = 0; i < FREE_ENTRIES; i++) begin
      tbl_start[i] = '0;
      tbl_len[i] = '0;
      tbl_used[i] = 1'b0;
    end
    heap_size = '0;
    reg_base = '0;
    reg_reserve = '0;
    reg_gran = 5'd12;

    // Rows under the reset settings (no reserve), then growth rows at base 0x10000
    dir_rows = '{
      '{OP_ALLOC, 48'h1,     48'h0,     1'b1, 48'h0,     STAT_RESERVE},
      '{OP_ALLOC, 48'h0,     48'h0,     1'b1, 48'h0,     STAT_RESERVE},
      '{OP_ALLOC, AMAX,      AMAX,      1'b1, 48'h0,     STAT_RESERVE},
      '{OP_FREE,  48'h0,     AMAX,      1'b1, 48'h0,     STAT_OK},
      '{OP_FREE,  48'h40,    48'h100,   1'b1, 48'h0,     STAT_OK},
      '{OP_FREE,  48'h8,     48'h100,   1'b1, 48'h0,     STAT_OK},
      '{OP_FREE,  48'h40,    48'h140,   1'b1, 48'h0,     STAT_OK},
      '{OP_ALLOC, 48'h0,     48'h0,     1'b1, 48'h100,   STAT_OK},
      '{OP_ALLOC, 48'h30,    48'h0,     1'b1, 48'h100,   STAT_OK},
      '{OP_ALLOC, 48'h50,    48'h0,     1'b1, 48'h130,   STAT_OK},
      '{OP_FREE,  48'h2,     AMAX,      1'b1, 48'h0,     STAT_OK},
      '{OP_ALLOC, 48'h2,     48'h0,     1'b1, AMAX,      STAT_OK},
      '{OP_ALLOC, 48'h10,    48'h0,     1'b0, 48'h0,     STAT_OK},
      '{OP_ALLOC, 48'h20,    48'h0,     1'b0, 48'h0,     STAT_OK},
      '{OP_FREE,  48'h10,    48'h10000, 1'b0, 48'h0,     STAT_OK},
      '{OP_FREE,  48'h20,    48'h10010, 1'b0, 48'h0,     STAT_OK},
      '{OP_ALLOC, 48'h2000,  48'h0,     1'b0, 48'h0,     STAT_OK},
      '{OP_ALLOC, 48'h0,     48'h0,     1'b0, 48'h0,     STAT_OK},
      '{OP_ALLOC, 48'h1001,  48'h0,     1'b0, 48'h0,     STAT_OK},
      '{OP_FREE,  48'h2000,  48'h10000, 1'b0, 48'h0,     STAT_OK},
      '{OP_ALLOC, AMAX,      AMAX,      1'b1, 48'h0,     STAT_RESERVE}
    };

    ph_base = '{48'h10000, 48'h0, 48'hffff_ffff_0000, 48'h1234_5678_9000,
                48'h7fff_0000_0000, AMAX};
    ph_rsv  = '{48'h100_0000, AMAX, AMAX, 48'h10_0000, 48'h0, 48'h4000_0000};
    ph_gran = '{5'd12, 5'd0, 5'd30, 5'd4, 5'd7, 5'd20};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part
    foreach (dir_rows[i]) begin
      if (i == GROW_ROW) configure(48'h10000, 48'h100_0000, 5'd12);
      issue(dir_rows[i], r);
    end

    // Random phases, one per register setting
    for (int p = 0; p < PHASES; p++) begin
      configure(ph_base[p], ph_rsv[p], ph_gran[p]);
      cnt = 0;
      while (cnt < PHASE_ITEMS) begin
        no_idle = (p == 1 && cnt < 150);
        // Start one long receiver hold-off; the sender keeps offering items
        if (p == 2 && cnt >= 40 && !hold_started) begin
          hold_req = 1'b1;
          wait (hold_cnt > 0);
          hold_req = 1'b0;
          hold_started = 1'b1;
        end
        k = $urandom_range(99);
        if (k < 40 || (k < 78 && live_blocks.size() == 0)) begin
          send(OP_ALLOC, rand_small_size(), rand_addr());
          cnt++;
        end else if (k < 78) begin
          // Return a live block; now and then only part of it
          n = $urandom_range(live_blocks.size() - 1);
          blk = live_blocks[n];
          live_blocks.delete(n);
          sz = ($urandom_range(9) == 0) ? addr_t'($urandom_range(1, 64)) : blk.size;
          send(OP_FREE, sz, blk.addr);
          cnt++;
        end else if (k < 86) begin
          // Fragment: carve many blocks, then free every other one
          burst.delete();
          sz = addr_t'($urandom_range(1, 256));
          n = $urandom_range(8, 40);
          for (int j = 0; j < n; j++) begin
            issue('{OP_ALLOC, sz, rand_addr(), 1'b0, '0, STAT_OK}, r);
            if (r.stat == STAT_OK) burst.push_back('{r.addr, sz});
            cnt++;
          end
          for (int j = 0; j < burst.size(); j += 2) begin
            send(OP_FREE, burst[j].size, burst[j].addr);
            cnt++;
          end
        end else if (k < 94) begin
          send(OP_FREE, ($urandom_range(3) == 0) ? rand_addr() : rand_small_size(),
               rand_addr());
          cnt++;
        end else begin
          send(OP_ALLOC, rand_addr(), rand_addr());
          cnt++;
        end
      end
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;
    @(posedge clk);

    // Drain and settle
    wait (pending_results.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_results.size() != 0) errors++;

    $display("covered %0d requests over %0d register settings: %0d allocations granted,",
             items_sent, PHASES + 2, n_alloc_ok);
    $display("%0d out-of-reserve and %0d table-full results, %0d mismatches",
             n_reserve, n_full, mismatches);
    if (errors == 0) begin
      $display("best_fit_coalescing_allocator_tb OK");
    end else begin
      $display("best_fit_coalescing_allocator_tb NOT OK");
    end
    $finish;
  end

endmodule
